// ===== src/dqm_pkg.sv =====
package dqm_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int OPCODE_W = 4;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ADD_FRONT    = 4'd0,
		OP_ADD_BACK     = 4'd1,
		OP_REMOVE_FRONT = 4'd2,
		OP_REMOVE_BACK  = 4'd3,
		OP_PEEK_FRONT   = 4'd4,
		OP_PEEK_BACK    = 4'd5,
		OP_DELETE_MATCH = 4'd6,
		OP_FIND         = 4'd7,
		OP_LIST_ALL     = 4'd8
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CM_HOLD,
		CM_PUSH_FRONT,
		CM_APPEND,
		CM_POP_FRONT,
		CM_DELETE,
		CM_ROTATE
	} cell_mode_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_LIST
	} fsm_t;

	typedef struct packed {
		cell_mode_t mode;
	} cell_ctl_t;

	typedef struct packed {
		logic in_use;
		logic is_tail;
		logic is_free;
	} cell_pos_t;

endpackage

// ===== src/dqm_req_if.sv =====
interface dqm_req_if;
	logic                         valid;
	logic                         ready;
	logic [dqm_pkg::OPCODE_W-1:0] opcode;
	logic [dqm_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink (input valid, input opcode, input value, output ready);
endinterface

// ===== src/dqm_rsp_if.sv =====
interface dqm_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [dqm_pkg::VALUE_W-1:0]  value_out;
	logic [dqm_pkg::STATUS_W-1:0] status;
	logic [dqm_pkg::COUNT_W-1:0]  item_count;
	logic                         last;

	modport source (output valid, output value_out, output status, output item_count,
		output last, input ready);
	modport sink (input valid, input value_out, input status, input item_count,
		input last, output ready);
endinterface

// ===== src/deque_with_match_delete_core.sv =====
// deque_with_match_delete_core: double-ended queue built as a chain of cells
// result: an accepted request's result is loaded into the output register by the edge that accepts it
// list_all: the request enters the list state, which then loads one entry per cycle while the output is free
// throughput: one request per cycle while the output register is free, for every opcode but a non-empty
// list_all, which holds off requests until its last entry has been loaded
// reset: arst_n clears the count, the state machine and the output valid; entries are undefined
module deque_with_match_delete_core #(
	parameter int DEPTH      = dqm_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = dqm_pkg::DATA_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	dqm_req_if.sink   req,
	dqm_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_WIDTH-1:0] key;
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic                  match_chain [DEPTH+1];
	logic [DATA_WIDTH-1:0] tail_chain [DEPTH+1];
	dqm_pkg::cell_ctl_t    ctl;

	dqm_pkg::fsm_t     state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  left_q, left_d;

	logic                         rsp_valid_q;
	logic [dqm_pkg::VALUE_W-1:0]  rsp_value_q, rsp_value_d;
	dqm_pkg::status_t             rsp_status_q, rsp_status_d;
	logic [dqm_pkg::COUNT_W-1:0]  rsp_count_q;
	logic                         rsp_last_q, rsp_last_d;
	logic                         load_rsp;

	logic accept, out_free, empty, full, found;

	assign key      = DATA_WIDTH'(req.value);
	assign out_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == dqm_pkg::FSM_IDLE) && out_free;
	assign accept   = req.valid && req.ready;
	assign empty    = (count_q == '0);
	assign full     = (count_q >= CNT_W'(DEPTH));

	assign match_chain[0] = 1'b0;
	assign tail_chain[0]  = '0;
	assign found          = match_chain[DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		dqm_pkg::cell_pos_t    pos;
		logic [DATA_WIDTH-1:0] left_data;
		logic [DATA_WIDTH-1:0] right_data;

		assign pos.in_use  = (CNT_W'(i) < count_q);
		assign pos.is_tail = (count_q == CNT_W'(i + 1));
		assign pos.is_free = (count_q == CNT_W'(i));

		if (i == 0) begin : g_first
			assign left_data = key;
		end else begin : g_mid
			assign left_data = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign right_data = cell_data[i];
		end else begin : g_inner
			assign right_data = cell_data[i+1];
		end

		dqm_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.pos       (pos),
			.key       (key),
			.left_data (left_data),
			.right_data(right_data),
			.wrap_data (cell_data[0]),
			.match_in  (match_chain[i]),
			.tail_in   (tail_chain[i]),
			.data      (cell_data[i]),
			.match_out (match_chain[i+1]),
			.tail_out  (tail_chain[i+1])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dqm_pkg::FSM_IDLE: begin
				if (accept && (req.opcode == dqm_pkg::OP_LIST_ALL) && !empty)
					state_d = dqm_pkg::FSM_LIST;
			end
			dqm_pkg::FSM_LIST: begin
				if (out_free && (left_q == CNT_W'(1))) state_d = dqm_pkg::FSM_IDLE;
			end
			default: state_d = dqm_pkg::FSM_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl.mode     = dqm_pkg::CM_HOLD;
		count_d      = count_q;
		left_d       = left_q;
		load_rsp     = 1'b0;
		rsp_value_d  = '0;
		rsp_status_d = dqm_pkg::ST_OK;
		rsp_last_d   = 1'b1;
		case (state_q)
			dqm_pkg::FSM_IDLE: begin
				if (accept) begin
					load_rsp = 1'b1;
					case (dqm_pkg::op_t'(req.opcode))
						dqm_pkg::OP_ADD_FRONT, dqm_pkg::OP_ADD_BACK: begin
							if (full) begin
								rsp_status_d = dqm_pkg::ST_FULL;
							end else begin
								ctl.mode = (req.opcode == dqm_pkg::OP_ADD_FRONT) ?
									dqm_pkg::CM_PUSH_FRONT : dqm_pkg::CM_APPEND;
								count_d  = count_q + CNT_W'(1);
							end
						end
						dqm_pkg::OP_REMOVE_FRONT, dqm_pkg::OP_PEEK_FRONT: begin
							if (empty) begin
								rsp_status_d = dqm_pkg::ST_EMPTY;
							end else begin
								rsp_value_d = dqm_pkg::VALUE_W'(cell_data[0]);
								if (req.opcode == dqm_pkg::OP_REMOVE_FRONT) begin
									ctl.mode = dqm_pkg::CM_POP_FRONT;
									count_d  = count_q - CNT_W'(1);
								end
							end
						end
						dqm_pkg::OP_REMOVE_BACK, dqm_pkg::OP_PEEK_BACK: begin
							if (empty) begin
								rsp_status_d = dqm_pkg::ST_EMPTY;
							end else begin
								rsp_value_d = dqm_pkg::VALUE_W'(tail_chain[DEPTH]);
								if (req.opcode == dqm_pkg::OP_REMOVE_BACK)
									count_d = count_q - CNT_W'(1);
							end
						end
						dqm_pkg::OP_DELETE_MATCH, dqm_pkg::OP_FIND: begin
							if (!found) begin
								rsp_status_d = dqm_pkg::ST_NOT_FOUND;
							end else begin
								rsp_value_d = dqm_pkg::VALUE_W'(key);
								if (req.opcode == dqm_pkg::OP_DELETE_MATCH) begin
									ctl.mode = dqm_pkg::CM_DELETE;
									count_d  = count_q - CNT_W'(1);
								end
							end
						end
						dqm_pkg::OP_LIST_ALL: begin
							if (empty) begin
								rsp_status_d = dqm_pkg::ST_EMPTY;
							end else begin
								load_rsp = 1'b0;
								left_d   = count_q;
							end
						end
						default: load_rsp = 1'b0;
					endcase
				end
			end
			dqm_pkg::FSM_LIST: begin
				if (out_free) begin
					load_rsp    = 1'b1;
					ctl.mode    = dqm_pkg::CM_ROTATE;
					rsp_value_d = dqm_pkg::VALUE_W'(cell_data[0]);
					rsp_last_d  = (left_q == CNT_W'(1));
					left_d      = left_q - CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dqm_pkg::FSM_IDLE;
			count_q     <= '0;
			left_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			left_q  <= left_d;
			if (load_rsp) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_value_q  <= rsp_value_d;
			rsp_status_q <= rsp_status_d;
			rsp_count_q  <= dqm_pkg::COUNT_W'(count_d);
			rsp_last_q   <= rsp_last_d;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.value_out  = rsp_value_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.item_count = rsp_count_q;
	assign rsp.last       = rsp_last_q;

endmodule

// ===== src/dqm_cell.sv =====
module dqm_cell #(
	parameter int DATA_WIDTH = dqm_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  dqm_pkg::cell_ctl_t    ctl,
	input  dqm_pkg::cell_pos_t    pos,
	input  logic [DATA_WIDTH-1:0] key,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	input  logic [DATA_WIDTH-1:0] wrap_data,
	input  logic                  match_in,
	input  logic [DATA_WIDTH-1:0] tail_in,
	output logic [DATA_WIDTH-1:0] data,
	output logic                  match_out,
	output logic [DATA_WIDTH-1:0] tail_out
);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] data_d;
	logic                  hit;

	assign hit       = pos.in_use && (data_q == key);
	assign match_out = match_in | hit;
	assign tail_out  = pos.is_tail ? data_q : tail_in;
	assign data      = data_q;

	always_comb begin
		data_d = data_q;
		case (ctl.mode)
			dqm_pkg::CM_PUSH_FRONT: data_d = left_data;
			dqm_pkg::CM_APPEND: begin
				if (pos.is_free) data_d = key;
			end
			dqm_pkg::CM_POP_FRONT: data_d = right_data;
			dqm_pkg::CM_DELETE: begin
				if (match_out) data_d = right_data;
			end
			dqm_pkg::CM_ROTATE: data_d = pos.is_tail ? wrap_data : right_data;
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import dqm_pkg::*;

	localparam int DEPTH          = DEPTH_DEF;
	localparam int RANDOM_ITEMS   = 430;
	localparam int HOLD_AFTER     = 120;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [VALUE_W-1:0]  value;
		logic                drain;
	} request_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value_out;
		status_t            status;
		logic [COUNT_W-1:0] item_count;
		logic               last;
	} result_t;

	logic clk;
	logic arst_n;
	bit   hold_off = 1'b0;

	dqm_req_if req_ch ();
	dqm_rsp_if rsp_ch ();

	deque_with_match_delete_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	request_t           request_plan[$];
	result_t            results_due[$];
	result_t            want;
	request_t           next_req;
	logic [VALUE_W-1:0] slots[DEPTH];
	logic [VALUE_W-1:0] pool[6];
	logic [31:0]        cyc = '0;
	int                 fill = 0;
	int                 send_gap;
	int                 recv_gap;
	int                 idle_cycles = 0;
	int                 n_accepted = 0;
	int                 n_results = 0;
	int                 n_err = 0;
	int                 n_planned;
	int                 op_hits[16] = '{default: 0};
	int                 stat_hits[4] = '{default: 0};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	function automatic int pick_gap(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void due(input logic [VALUE_W-1:0] v, input status_t st, input logic fin);
		result_t r;
		r.value_out = v;
		r.status = st;
		r.item_count = fill[COUNT_W-1:0];
		r.last = fin;
		results_due.push_back(r);
	endfunction

	function automatic void drop_slot(input int idx);
		for (int i = idx; i + 1 < fill; i++)
			slots[i] = slots[i + 1];
		fill--;
	endfunction

	// deque behavior, one call per accepted request
	function automatic void apply_request(input logic [OPCODE_W-1:0] op,
		input logic [VALUE_W-1:0] v);
		int hit;
		logic [VALUE_W-1:0] w;
		hit = -1;
		w = '0;
		case (op)
			OP_ADD_FRONT, OP_ADD_BACK: begin
				if (fill >= DEPTH) begin
					due('0, ST_FULL, 1'b1);
				end else begin
					if (op == OP_ADD_FRONT) begin
						for (int i = fill; i > 0; i--)
							slots[i] = slots[i - 1];
						slots[0] = v;
					end else begin
						slots[fill] = v;
					end
					fill++;
					due('0, ST_OK, 1'b1);
				end
			end
			OP_REMOVE_FRONT, OP_REMOVE_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
				if (fill == 0) begin
					due('0, ST_EMPTY, 1'b1);
				end else begin
					hit = (op == OP_REMOVE_FRONT || op == OP_PEEK_FRONT) ? 0 : fill - 1;
					w = slots[hit];
					if (op == OP_REMOVE_FRONT)
						drop_slot(0);
					else if (op == OP_REMOVE_BACK)
						fill--;
					due(w, ST_OK, 1'b1);
				end
			end
			OP_DELETE_MATCH, OP_FIND: begin
				for (int i = fill - 1; i >= 0; i--)
					if (slots[i] == v)
						hit = i;
				if (hit < 0) begin
					due('0, ST_NOT_FOUND, 1'b1);
				end else begin
					w = slots[hit];
					if (op == OP_DELETE_MATCH)
						drop_slot(hit);
					due(w, ST_OK, 1'b1);
				end
			end
			OP_LIST_ALL: begin
				if (fill == 0) begin
					due('0, ST_EMPTY, 1'b1);
				end else begin
					for (int i = 0; i < fill; i++)
						due(slots[i], ST_OK, i == fill - 1);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void queue_request(input logic [OPCODE_W-1:0] op,
		input logic [VALUE_W-1:0] v);
		request_t r;
		r.opcode = op;
		r.value = v;
		r.drain = 1'b0;
		request_plan.push_back(r);
	endfunction

	function automatic void queue_drain();
		request_t r;
		r = '0;
		r.drain = 1'b1;
		request_plan.push_back(r);
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value(input int pool_pct);
		if ($urandom_range(0, 99) < pool_pct)
			return pool[$urandom_range(0, 5)];
		return $urandom;
	endfunction

	// growing phases lean on adds, shrinking phases on removes and deletes
	function automatic logic [OPCODE_W-1:0] pick_op(input bit growing);
		int r;
		r = $urandom_range(0, 99);
		if (growing) begin
			if (r < 35) return OP_ADD_BACK;
			if (r < 60) return OP_ADD_FRONT;
			if (r < 65) return OP_REMOVE_FRONT;
			if (r < 70) return OP_REMOVE_BACK;
			if (r < 73) return OP_PEEK_FRONT;
			if (r < 76) return OP_PEEK_BACK;
			if (r < 84) return OP_FIND;
			if (r < 90) return OP_DELETE_MATCH;
			if (r < 97) return OP_LIST_ALL;
		end else begin
			if (r < 5) return OP_ADD_BACK;
			if (r < 10) return OP_ADD_FRONT;
			if (r < 35) return OP_REMOVE_FRONT;
			if (r < 60) return OP_REMOVE_BACK;
			if (r < 63) return OP_PEEK_FRONT;
			if (r < 66) return OP_PEEK_BACK;
			if (r < 74) return OP_FIND;
			if (r < 86) return OP_DELETE_MATCH;
			if (r < 96) return OP_LIST_ALL;
		end
		return OPCODE_W'($urandom_range(9, 15));
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.opcode <= '0;
			req_ch.value <= '0;
			send_gap <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				apply_request(req_ch.opcode, req_ch.value);
				op_hits[req_ch.opcode]++;
				n_accepted++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					req_ch.valid <= 1'b0;
				end else if (request_plan.size() > 0 && request_plan[0].drain) begin
					req_ch.valid <= 1'b0;
					if (results_due.size() == 0 && !rsp_ch.valid)
						void'(request_plan.pop_front());
				end else if (request_plan.size() > 0) begin
					next_req = request_plan.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.opcode <= next_req.opcode;
					req_ch.value <= next_req.value;
					send_gap <= pick_gap(cyc[8:7] == 2'b00);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_results++;
				if (results_due.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("unexpected result: value_out=%h status=%0d item_count=%0d last=%0d",
							rsp_ch.value_out, rsp_ch.status, rsp_ch.item_count, rsp_ch.last);
				end else begin
					want = results_due.pop_front();
					stat_hits[want.status]++;
					if (rsp_ch.value_out !== want.value_out || rsp_ch.status !== want.status ||
						rsp_ch.item_count !== want.item_count || rsp_ch.last !== want.last) begin
						n_err++;
						if (n_err <= 10) begin
							$write("result %0d mismatch: expected value_out=%h status=%0d",
								n_results, want.value_out, want.status);
							$write(" item_count=%0d last=%0d,", want.item_count, want.last);
							$display(" got value_out=%h status=%0d item_count=%0d last=%0d",
								rsp_ch.value_out, rsp_ch.status, rsp_ch.item_count,
								rsp_ch.last);
						end
					end
				end
			end
			if (hold_off) begin
				rsp_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				recv_gap <= pick_gap(cyc[8:7] == 2'b01);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// long receiver stall so the block backs up
	initial begin
		@(posedge arst_n);
		while (n_accepted < HOLD_AFTER)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		request_t plan_req;
		n_planned = 0;
		pool[0] = '0;
		pool[1] = '1;
		for (int i = 2; i < 6; i++)
			pool[i] = $urandom;

		// empty queue corners
		queue_request(OP_LIST_ALL, '0);
		queue_request(OP_REMOVE_FRONT, '0);
		queue_request(OP_REMOVE_BACK, '0);
		queue_request(OP_PEEK_FRONT, '0);
		queue_request(OP_PEEK_BACK, '0);
		queue_request(OP_DELETE_MATCH, '0);
		queue_request(OP_FIND, '0);
		// both ends, extremes, duplicate keys
		queue_request(OP_ADD_BACK, '0);
		queue_request(OP_ADD_BACK, '1);
		queue_request(OP_ADD_FRONT, 32'hA5A5_A5A5);
		queue_request(OP_ADD_BACK, '0);
		queue_request(OP_PEEK_FRONT, '0);
		queue_request(OP_PEEK_BACK, '0);
		queue_request(OP_LIST_ALL, '0);
		queue_request(OP_FIND, '1);
		queue_request(OP_FIND, 32'h1234_5678);
		queue_request(OP_DELETE_MATCH, 32'h5A5A_5A5A);
		queue_request(OP_DELETE_MATCH, '0);
		queue_request(OP_LIST_ALL, '0);
		queue_request(4'd9, '1);
		queue_request(4'd15, 32'h5555_5555);
		queue_request(OP_REMOVE_BACK, '0);
		queue_request(OP_REMOVE_FRONT, '0);
		queue_request(OP_DELETE_MATCH, '1);
		queue_request(OP_LIST_ALL, '0);
		queue_drain();

		while (n_planned < RANDOM_ITEMS) begin
			plan_req.opcode = pick_op(((n_planned / 40) % 2) == 0);
			if (plan_req.opcode == OP_ADD_FRONT || plan_req.opcode == OP_ADD_BACK)
				plan_req.value = pick_value(60);
			else if (plan_req.opcode == OP_FIND || plan_req.opcode == OP_DELETE_MATCH)
				plan_req.value = pick_value(80);
			else
				plan_req.value = $urandom;
			queue_request(plan_req.opcode, plan_req.value);
			if (plan_req.opcode <= OP_LIST_ALL)
				n_planned++;
			if (n_planned == RANDOM_ITEMS / 2 && plan_req.opcode <= OP_LIST_ALL)
				queue_drain();
		end

		@(posedge arst_n);
		while (request_plan.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("requests: %0d adds, %0d removes, %0d peeks, %0d deletes, %0d finds, %0d lists",
			op_hits[OP_ADD_FRONT] + op_hits[OP_ADD_BACK],
			op_hits[OP_REMOVE_FRONT] + op_hits[OP_REMOVE_BACK],
			op_hits[OP_PEEK_FRONT] + op_hits[OP_PEEK_BACK],
			op_hits[OP_DELETE_MATCH], op_hits[OP_FIND], op_hits[OP_LIST_ALL]);
		$display("%0d results checked (ok %0d, empty %0d, full %0d, not found %0d), %0d mismatches",
			n_results, stat_hits[ST_OK], stat_hits[ST_EMPTY], stat_hits[ST_FULL],
			stat_hits[ST_NOT_FOUND], n_err);
		if (n_err == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
